// ===== rtl/three_buffer_block_mapper_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-buffer block mapper
// Shared property shapes: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef THREE_BUFFER_BLOCK_MAPPER_TOP_ASSERT_SVH
`define THREE_BUFFER_BLOCK_MAPPER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TBBM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbbm: same-cycle implication failed");

// next-cycle implication, checked outside reset
`define TBBM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbbm: next-cycle implication failed");

`endif

// ===== rtl/tbbm_pkg.sv =====
// ----------------------------------------------------------------------------
// tbbm_pkg
// Constants, buffer codes and shared types of the three-buffer block mapper.
// ----------------------------------------------------------------------------
package tbbm_pkg;

  localparam int OFFSET_FIELD_BITS = 7;
  localparam int BYTE_SHIFT        = 2;
  localparam int BLOCK_FIELD_BITS  = 13;
  localparam int BLOCK_LIMIT       = 4096;
  localparam int BUFFER_BYTES      = 512;

  localparam int ADDR_W = 32;
  localparam int BLK_W  = BLOCK_FIELD_BITS;
  localparam int OFF_W  = $clog2(BUFFER_BYTES);
  localparam int LEFT_W = OFF_W + 1;

  typedef enum logic [1:0] {
    SEL_FIRST  = 2'd0,
    SEL_SECOND = 2'd1,
    SEL_WRITE  = 2'd2
  } buf_sel_t;

  typedef struct packed {
    logic [BLK_W-1:0] first_blk;
    logic [BLK_W-1:0] second_blk;
    logic [BLK_W-1:0] write_blk;
    logic             first_v;
    logic             second_v;
    logic             write_v;
    logic             first_dirty;
    logic             second_dirty;
    logic             last_second;
  } tag_state_t;

  typedef struct packed {
    logic             too_large;
    logic [BLK_W-1:0] block_number;
    logic             fill_valid;
    buf_sel_t         writeback_buffer;
    logic [BLK_W-1:0] writeback_block;
    logic             writeback_valid;
    logic [LEFT_W-1:0] bytes_left;
    logic [OFF_W-1:0] byte_offset;
    buf_sel_t         buffer_select;
  } map_result_t;

endpackage

// ===== rtl/tbbm_map.sv =====
// ----------------------------------------------------------------------------
// tbbm_map
// Address split, three-way tag lookup, replacement choice and next tag state.
// ----------------------------------------------------------------------------
module tbbm_map (
  input  logic [tbbm_pkg::ADDR_W-1:0] line_address,
  input  logic                        is_write,
  input  tbbm_pkg::tag_state_t        cur,
  output tbbm_pkg::tag_state_t        nxt,
  output tbbm_pkg::map_result_t       res
);

  localparam int SH_W = tbbm_pkg::ADDR_W + tbbm_pkg::BYTE_SHIFT;

  logic [SH_W-1:0]                 shifted;
  logic [tbbm_pkg::ADDR_W-1:0]     blk_raw;
  logic [tbbm_pkg::BLK_W-1:0]      blk;
  logic [tbbm_pkg::OFF_W-1:0]      off;
  logic                            big;
  logic                            hit_first;
  logic                            hit_second;
  logic                            hit_write;

  assign shifted = SH_W'(line_address) << tbbm_pkg::BYTE_SHIFT;
  assign off     = shifted[tbbm_pkg::OFF_W-1:0];
  assign blk_raw = line_address >> tbbm_pkg::OFFSET_FIELD_BITS;
  assign blk     = blk_raw[tbbm_pkg::BLK_W-1:0];
  assign big     = {1'b0, blk} >= (tbbm_pkg::BLK_W+1)'(tbbm_pkg::BLOCK_LIMIT);

  assign hit_first  = cur.first_v  && (blk == cur.first_blk);
  assign hit_second = cur.second_v && (blk == cur.second_blk);
  assign hit_write  = cur.write_v  && (blk == cur.write_blk);

  always_comb begin
    nxt = cur;
    res.too_large        = big;
    res.block_number     = blk;
    res.byte_offset      = off;
    res.bytes_left       = tbbm_pkg::LEFT_W'(tbbm_pkg::BUFFER_BYTES) - {1'b0, off};
    res.buffer_select    = tbbm_pkg::SEL_FIRST;
    res.writeback_valid  = 1'b0;
    res.writeback_block  = '0;
    res.writeback_buffer = tbbm_pkg::SEL_FIRST;
    res.fill_valid       = 1'b0;

    priority if (big) begin
      // rejected: state stays as it is
    end else if (hit_first) begin
      if (is_write) begin
        nxt.first_dirty = 1'b1;
      end
      nxt.last_second   = 1'b0;
      res.buffer_select = tbbm_pkg::SEL_FIRST;
    end else if (hit_second) begin
      if (is_write) begin
        nxt.second_dirty = 1'b1;
      end
      nxt.last_second   = 1'b1;
      res.buffer_select = tbbm_pkg::SEL_SECOND;
    end else if (hit_write) begin
      res.buffer_select = tbbm_pkg::SEL_WRITE;
    end else if (!is_write) begin
      res.fill_valid = 1'b1;
      // replace the read buffer that was not used last
      if (!cur.last_second) begin
        if (cur.second_dirty) begin
          res.writeback_valid  = 1'b1;
          res.writeback_block  = cur.second_blk;
          res.writeback_buffer = tbbm_pkg::SEL_SECOND;
        end
        nxt.second_dirty  = 1'b0;
        nxt.second_blk    = blk;
        nxt.second_v      = 1'b1;
        nxt.last_second   = 1'b1;
        res.buffer_select = tbbm_pkg::SEL_SECOND;
      end else begin
        if (cur.first_dirty) begin
          res.writeback_valid  = 1'b1;
          res.writeback_block  = cur.first_blk;
          res.writeback_buffer = tbbm_pkg::SEL_FIRST;
        end
        nxt.first_dirty   = 1'b0;
        nxt.first_blk     = blk;
        nxt.first_v       = 1'b1;
        nxt.last_second   = 1'b0;
        res.buffer_select = tbbm_pkg::SEL_FIRST;
      end
    end else begin
      // write miss: flush whatever the write buffer holds, claim it, no fill
      if (cur.write_v) begin
        res.writeback_valid  = 1'b1;
        res.writeback_block  = cur.write_blk;
        res.writeback_buffer = tbbm_pkg::SEL_WRITE;
      end
      nxt.write_blk     = blk;
      nxt.write_v       = 1'b1;
      res.buffer_select = tbbm_pkg::SEL_WRITE;
    end
  end

endmodule

// ===== rtl/tbbm_tags.sv =====
// ----------------------------------------------------------------------------
// tbbm_tags
// Held block numbers, valid and dirty flags and the read-buffer recency bit.
// ----------------------------------------------------------------------------
`include "three_buffer_block_mapper_top_assert.svh"

module tbbm_tags (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  logic                 rejected,
  input  tbbm_pkg::tag_state_t nxt,
  output tbbm_pkg::tag_state_t state
);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (update) begin
      state <= nxt;
    end
  end

  `TBBM_ASSERT_IMP(a_first_dirty_held, clk, rst, state.first_dirty, state.first_v)
  `TBBM_ASSERT_IMP(a_second_dirty_held, clk, rst, state.second_dirty, state.second_v)
  `TBBM_ASSERT_NXT(a_reject_keeps_tags, clk, rst, update && rejected, $stable(state))

endmodule

// ===== rtl/three_buffer_block_mapper_top.sv =====
// An accepted request is held in the input register, mapped, and registered in
// the result register, from which it is offered on the output stream.
// Throughput: one request per cycle unless the output stalls; a request's tag
// update lands in the same edge as its result, so the next request sees it.
// Reset (rst, synchronous): all three buffers empty and clean, first read
// buffer marked as used last, both pipeline registers empty.
// ----------------------------------------------------------------------------
// three_buffer_block_mapper_top
// Stream wrapper: input register, mapping logic, tag store, result register.
// ----------------------------------------------------------------------------
module three_buffer_block_mapper_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] line_address
  input  logic        s_axis_tuser,  // [0] is_write
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] buffer_select, [10:2] byte_offset, [20:11] bytes_left,
  // [21] writeback_valid, [34:22] writeback_block, [36:35] writeback_buffer,
  // [37] fill_valid, [50:38] block_number, [51] too_large, [55:52] zero
  output logic [55:0] m_axis_tdata
);

  localparam int RES_W = $bits(tbbm_pkg::map_result_t);

  logic                        in_v;
  logic [tbbm_pkg::ADDR_W-1:0] in_addr;
  logic                        in_wr;
  logic                        out_v;
  tbbm_pkg::map_result_t       out_res;
  logic                        advance;
  tbbm_pkg::tag_state_t        state;
  tbbm_pkg::tag_state_t        state_next;
  tbbm_pkg::map_result_t       res;

  assign advance       = in_v && (!out_v || m_axis_tready);
  assign s_axis_tready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tready) begin
      in_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_addr <= s_axis_tdata;
      in_wr   <= s_axis_tuser;
    end
  end

  tbbm_map u_map (
    .line_address (in_addr),
    .is_write     (in_wr),
    .cur          (state),
    .nxt          (state_next),
    .res          (res)
  );

  tbbm_tags u_tags (
    .clk      (clk),
    .rst      (rst),
    .update   (advance),
    .rejected (res.too_large),
    .nxt      (state_next),
    .state    (state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= 1'b1;
    end else if (m_axis_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {(56 - RES_W)'(0), out_res};

endmodule

// ===== tb/three_buffer_block_mapper_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_buffer_block_mapper_top_tb
// Drives line-address requests into the mapper and checks every mapping
// result against a behavioral tag model kept in a small scoreboard class.
// A directed run covers hits, clean and dirty read misses, write misses and
// out-of-range blocks. A random run follows, drawn mostly from a small pool
// of blocks so that hits and evictions stay frequent. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
class block_map_scoreboard;
  tbbm_pkg::tag_state_t  tags;
  tbbm_pkg::map_result_t pending_maps[$];
  int                    errors;

  function new();
    tags   = '0;
    errors = 0;
  endfunction

  function int outstanding();
    return pending_maps.size();
  endfunction

  function void report(input string what);
    errors++;
    if (errors <= 10) $display("mapper mismatch %0d: %s", errors, what);
  endfunction

  // Map one accepted request onto the three buffers and queue the result.
  function void note_request(input logic [tbbm_pkg::ADDR_W-1:0] addr, input logic wr);
    tbbm_pkg::map_result_t      r;
    logic [tbbm_pkg::BLK_W-1:0] blk;
    r   = '0;
    blk = addr[tbbm_pkg::OFFSET_FIELD_BITS +: tbbm_pkg::BLK_W];
    r.block_number = blk;
    r.byte_offset  = tbbm_pkg::OFF_W'((addr << tbbm_pkg::BYTE_SHIFT) %
                                      tbbm_pkg::BUFFER_BYTES);
    r.bytes_left   = tbbm_pkg::LEFT_W'(tbbm_pkg::BUFFER_BYTES - int'(r.byte_offset));
    if (int'(blk) >= tbbm_pkg::BLOCK_LIMIT) begin
      r.too_large = 1'b1;
    end else if (tags.first_v && blk == tags.first_blk) begin
      if (wr) tags.first_dirty = 1'b1;
      tags.last_second = 1'b0;
      r.buffer_select  = tbbm_pkg::SEL_FIRST;
    end else if (tags.second_v && blk == tags.second_blk) begin
      if (wr) tags.second_dirty = 1'b1;
      tags.last_second = 1'b1;
      r.buffer_select  = tbbm_pkg::SEL_SECOND;
    end else if (tags.write_v && blk == tags.write_blk) begin
      r.buffer_select = tbbm_pkg::SEL_WRITE;
    end else if (!wr) begin
      // read miss: replace the read buffer not used last
      r.fill_valid = 1'b1;
      if (!tags.last_second) begin
        if (tags.second_dirty) begin
          r.writeback_valid  = 1'b1;
          r.writeback_block  = tags.second_blk;
          r.writeback_buffer = tbbm_pkg::SEL_SECOND;
        end
        tags.second_dirty = 1'b0;
        tags.second_blk   = blk;
        tags.second_v     = 1'b1;
        tags.last_second  = 1'b1;
        r.buffer_select   = tbbm_pkg::SEL_SECOND;
      end else begin
        if (tags.first_dirty) begin
          r.writeback_valid  = 1'b1;
          r.writeback_block  = tags.first_blk;
          r.writeback_buffer = tbbm_pkg::SEL_FIRST;
        end
        tags.first_dirty = 1'b0;
        tags.first_blk   = blk;
        tags.first_v     = 1'b1;
        tags.last_second = 1'b0;
        r.buffer_select  = tbbm_pkg::SEL_FIRST;
      end
    end else begin
      // write miss: flush whatever the write buffer holds, no fill
      if (tags.write_v) begin
        r.writeback_valid  = 1'b1;
        r.writeback_block  = tags.write_blk;
        r.writeback_buffer = tbbm_pkg::SEL_WRITE;
      end
      tags.write_blk  = blk;
      tags.write_v    = 1'b1;
      r.buffer_select = tbbm_pkg::SEL_WRITE;
    end
    pending_maps.push_back(r);
  endfunction

  function void check_result(input logic [55:0] data);
    tbbm_pkg::map_result_t want;
    tbbm_pkg::map_result_t got;
    string                 bad;
    if (pending_maps.size() == 0) begin
      report($sformatf("unexpected result %h", data));
      return;
    end
    want = pending_maps.pop_front();
    got  = tbbm_pkg::map_result_t'(data[51:0]);
    bad  = "";
    if (got.buffer_select !== want.buffer_select)       bad = {bad, " buffer_select"};
    if (got.byte_offset !== want.byte_offset)           bad = {bad, " byte_offset"};
    if (got.bytes_left !== want.bytes_left)             bad = {bad, " bytes_left"};
    if (got.writeback_valid !== want.writeback_valid)   bad = {bad, " writeback_valid"};
    if (got.writeback_block !== want.writeback_block)   bad = {bad, " writeback_block"};
    if (got.writeback_buffer !== want.writeback_buffer) bad = {bad, " writeback_buffer"};
    if (got.fill_valid !== want.fill_valid)             bad = {bad, " fill_valid"};
    if (got.block_number !== want.block_number)         bad = {bad, " block_number"};
    if (got.too_large !== want.too_large)               bad = {bad, " too_large"};
    if (data[55:52] !== 4'h0)                           bad = {bad, " padding"};
    if (bad != "")
      report($sformatf("fields%s expected %h got %h", bad, {4'h0, want}, data));
  endfunction
endclass

module three_buffer_block_mapper_top_tb;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_COUNT = 600;
  localparam int POOL_SIZE    = 5;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] line_address
  logic        s_axis_tuser = 1'b0; // [0] is_write
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // see port list of the block for fields

  logic        steady = 1'b0;       // no idling on either side while set
  int          idle_cycles = 0;

  block_map_scoreboard maps = new();

  three_buffer_block_mapper_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] line_addr(input logic [11:0] upper,
                                            input int blk, input int line);
    return {upper, tbbm_pkg::BLK_W'(blk), 7'(line)};
  endfunction

  task automatic send_access(input logic [31:0] addr, input logic wr);
    while (!steady && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= wr;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    maps.note_request(addr, wr);
  endtask

  // Hold off new requests until every queued result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (maps.outstanding() > 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) maps.check_result(m_axis_tdata);
    m_axis_tready <= !rst && (steady || $urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("three_buffer_block_mapper_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int          pool [POOL_SIZE];
    int          blk;
    int          pick;
    logic [31:0] addr;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fills, dirty evictions, write buffer, range limit
    send_access(32'h0000_0000, 1'b0);              // read miss into second, clean
    send_access(line_addr(12'h0, 0, 127), 1'b1);   // write hit second, dirty
    send_access(line_addr(12'h0, 5, 1), 1'b0);     // read miss into first, clean
    send_access(line_addr(12'h0, 5, 2), 1'b1);     // write hit first, dirty
    send_access(line_addr(12'h0, 9, 3), 1'b0);     // evict dirty second
    send_access(line_addr(12'h0, 12, 4), 1'b0);    // evict dirty first
    send_access(line_addr(12'h0, 100, 5), 1'b1);   // write miss, empty write buffer
    send_access(line_addr(12'h0, 100, 6), 1'b0);   // read hit on write buffer
    send_access(line_addr(12'h0, 100, 7), 1'b1);   // write hit on write buffer
    send_access(line_addr(12'h0, 4095, 8), 1'b1);  // write miss, flush write buffer
    send_access(32'hFFFF_FFFF, 1'b0);              // block out of range
    send_access(line_addr(12'h0, 4096, 0), 1'b1);  // lowest out-of-range block
    send_access(line_addr(12'hFFF, 4095, 0), 1'b0);
    send_access(line_addr(12'h0, 9, 10), 1'b0);    // read hit second
    send_access(line_addr(12'h0, 12, 11), 1'b0);   // read hit first
    send_access(line_addr(12'h0, 9, 12), 1'b1);    // dirty second
    send_access(line_addr(12'h0, 12, 13), 1'b1);   // dirty first
    send_access(line_addr(12'hFFF, 0, 14), 1'b0);  // first used last: evict second
    send_access(line_addr(12'h0, 7, 15), 1'b1);    // write miss, flush 4095
    send_access(line_addr(12'h0, 0, 0), 1'b0);     // hit second after refill
    drain_results();

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i % 100 == 0) begin
        foreach (pool[k]) pool[k] = $urandom_range(tbbm_pkg::BLOCK_LIMIT - 1);
        if (i == 200) begin
          pool[0] = 0;
          pool[1] = tbbm_pkg::BLOCK_LIMIT - 1;
        end
      end
      steady <= (i >= 150 && i < 270);
      if (i == 300) drain_results();
      pick = $urandom_range(99);
      if (pick < 80)      blk = pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 90) blk = $urandom_range((1 << tbbm_pkg::BLK_W) - 1,
                                               tbbm_pkg::BLOCK_LIMIT);
      else                blk = $urandom_range(tbbm_pkg::BLOCK_LIMIT - 1);
      addr = line_addr(12'($urandom), blk, $urandom_range(127));
      send_access(addr, $urandom_range(99) < 40);
    end
    steady <= 1'b0;
    drain_results();
    repeat (4) @(posedge clk);

    if (maps.errors == 0 && maps.outstanding() == 0)
      $display("three_buffer_block_mapper_top_tb OK");
    else
      $display("three_buffer_block_mapper_top_tb NOT OK");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tbbm_pkg.sv
rtl/tbbm_map.sv
rtl/tbbm_tags.sv
rtl/three_buffer_block_mapper_top.sv
tb/three_buffer_block_mapper_top_tb.sv
